FILE: design/lrgd_pkg.sv
// Shared types and constants for the gradient-descent line fitter.
// No dependencies.
package lrgd_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam logic [15:0] STEP_RATE_RST = 16'd3277;
  localparam logic [15:0] PASS_COUNT_RST = 16'd1000;

  localparam logic [0:0] REG_STEP_RATE = 1'b0;
  localparam logic [0:0] REG_PASS_COUNT = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,    // taking points
    ST_PASS,    // start of a pass: clear sums, point index 0
    ST_READ,    // read one point from store, or start divider after the last
    ST_MUL1,    // x*slope
    ST_MUL2,    // residual*x
    ST_ACC,     // accumulate sums
    ST_UPD,     // unused: goes straight to ST_DIV
    ST_DIV,     // wait on divider
    ST_APPLY,   // apply deltas
    ST_OUT      // result waits for transfer
  } state_t;

  typedef struct packed {
    logic clr_params;
    logic clr_sums;
    logic clr_idx;
    logic rd;
    logic mul1;
    logic mul2;
    logic acc;
    logic div_start;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic last_point;
    logic div_done;
  } sts_t;

endpackage

FILE: design/lrgd_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned.
// Uses lrgd_pkg.
module lrgd_div #(
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic [DW:0]   rem,
  output logic          done
);
  import lrgd_pkg::*;
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], quo[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: design/lrgd_datapath.sv
// Point store, residual arithmetic, gradient sums and parameter update.
// Uses lrgd_pkg and lrgd_div.
module lrgd_datapath #(
  parameter int MAX_POINTS = lrgd_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  lrgd_pkg::cmd_t      cmd,
  output lrgd_pkg::sts_t      sts,
  input  logic                load,
  input  logic [15:0]         in_x,
  input  logic signed [31:0]  in_y,
  input  logic [15:0]         step_rate,
  output logic signed [31:0]  slope,
  output logic signed [31:0]  intercept,
  output logic                sat
);
  import lrgd_pkg::*;
  localparam int AW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};

  logic [15:0]        xmem [MAX_POINTS];
  logic signed [31:0] ymem [MAX_POINTS];
  logic [NW-1:0]      total;
  logic [NW-1:0]      idx;
  logic [15:0]        rx;
  logic signed [31:0] ry;
  logic signed [49:0] p;
  logic signed [33:0] r;
  logic signed [51:0] q;
  logic signed [47:0] ssum, isum;
  logic               div_sel;

  // point load; a point with the store full is dropped and flagged
  always_ff @(posedge clk) begin
    if (load && total != NW'(MAX_POINTS)) begin
      xmem[total[AW-1:0]] <= in_x;
      ymem[total[AW-1:0]] <= in_y;
    end
    if (cmd.rd) begin
      rx <= xmem[idx[AW-1:0]];
      ry <= ymem[idx[AW-1:0]];
    end
  end

  // residual path
  logic signed [49:0] p_rnd;
  logic signed [33:0] r_next;
  logic signed [51:0] q_prod;
  assign p_rnd  = (p + 50'sd32768) >>> 16;
  assign r_next = 34'(p_rnd) + 34'(intercept) - 34'(ry);

  always_ff @(posedge clk) begin
    if (cmd.mul1) p <= $signed({1'b0, rx}) * slope;
    if (cmd.mul2) begin
      r <= r_next;
      q <= r_next * $signed({1'b0, rx});
    end
  end

  logic signed [51:0] q_rnd;
  logic signed [48:0] s_add, i_add;
  assign q_rnd = (q + 52'sd32768) >>> 16;
  assign s_add = 49'(ssum) + 49'(q_rnd);
  assign i_add = 49'(isum) + 49'(r);

  // delta = round(rate*S/(n*2^16)) via magnitude divide, one sum at a time
  logic signed [47:0] dsum;
  logic signed [64:0] prod;
  logic [63:0]        mag;
  logic [NW+15:0]     den;
  logic [63:0]        quo;
  logic [NW+16:0]     rem;
  logic               ddone;
  logic               div_second;
  logic signed [64:0] sdelta, idelta;
  logic signed [64:0] delta_now;

  // slope divide finishing starts the intercept divide in the same cycle
  assign div_second = ddone && !div_sel;
  assign dsum = (div_sel || div_second) ? isum : ssum;
  assign prod = $signed({1'b0, step_rate}) * dsum;
  assign mag  = prod[64] ? 64'(-prod) : 64'(prod);
  assign den  = {total, 16'd0};

  lrgd_div #(.NW(64), .DW(NW + 16)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start || div_second),
    .num(mag), .den(den), .quo(quo), .rem(rem), .done(ddone)
  );

  logic sign_hold;
  logic [63:0] qr;
  assign qr = quo + ((rem >= ({1'b0, den} - ({1'b0, den} >> 1))) ? 64'd1 : 64'd0);
  assign delta_now = sign_hold ? -$signed({1'b0, qr}) : $signed({1'b0, qr});

  logic signed [65:0] snew, inew;
  assign snew = 66'(slope) - 66'(sdelta);
  assign inew = 66'(intercept) - 66'(idelta);

  function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      sat   <= 1'b0;
      div_sel <= 1'b0;
      slope <= '0;
      intercept <= '0;
    end else begin
      if (load) begin
        if (total == NW'(MAX_POINTS)) sat <= 1'b1;
        else total <= total + 1'b1;
      end
      if (cmd.clr_params) begin
        slope <= '0;
        intercept <= '0;
      end
      if (cmd.div_start) begin
        div_sel   <= 1'b0;
        sign_hold <= prod[64];
      end
      if (ddone) begin
        if (!div_sel) begin
          sdelta    <= delta_now;
          div_sel   <= 1'b1;
          sign_hold <= prod[64];
        end else begin
          idelta  <= delta_now;
          div_sel <= 1'b0;
        end
      end
      if (cmd.clr_sums) begin
        ssum <= '0;
        isum <= '0;
      end
      if (cmd.acc) begin
        if (s_add > 49'(SUM_MAX)) begin ssum <= SUM_MAX; sat <= 1'b1; end
        else if (s_add < 49'(SUM_MIN)) begin ssum <= SUM_MIN; sat <= 1'b1; end
        else ssum <= s_add[47:0];
        if (i_add > 49'(SUM_MAX)) begin isum <= SUM_MAX; sat <= 1'b1; end
        else if (i_add < 49'(SUM_MIN)) begin isum <= SUM_MIN; sat <= 1'b1; end
        else isum <= i_add[47:0];
      end
      if (cmd.apply) begin
        slope     <= clip32(snew);
        intercept <= clip32(inew);
        if (snew != 66'(clip32(snew)) || inew != 66'(clip32(inew))) sat <= 1'b1;
      end
      if (cmd.clr_idx && !cmd.clr_sums) total <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_sums) idx <= '0;
    else if (cmd.acc) idx <= idx + 1'b1;
  end

  assign sts.last_point = (idx == total);
  assign sts.div_done   = ddone && div_sel;
endmodule

FILE: design/lrgd_ctrl.sv
// Sequencer for load, passes, update and result transfer.
// Uses lrgd_pkg.
module lrgd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic            in_last,
  input  logic [15:0]     pass_count,
  input  lrgd_pkg::sts_t  sts,
  output lrgd_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_stall
);
  import lrgd_pkg::*;

  state_t      state, state_next;
  logic [15:0] pass_left, pass_left_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      pass_left <= '0;
    end else begin
      state     <= state_next;
      pass_left <= pass_left_next;
    end
  end

  always_comb begin
    state_next     = state;
    pass_left_next = pass_left;
    cmd            = '0;
    busy           = 1'b1;
    out_valid      = 1'b0;
    case (state)
      ST_LOAD: begin
        busy = 1'b0;
        if (in_fire && in_last) begin
          cmd.clr_params = 1'b1;
          pass_left_next = pass_count;
          state_next     = (pass_count == 16'd0) ? ST_OUT : ST_PASS;
        end
      end
      ST_PASS: begin
        cmd.clr_sums = 1'b1;
        state_next   = ST_READ;
      end
      ST_READ: begin
        if (sts.last_point) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = ST_READ;
      end
      ST_UPD: state_next = ST_DIV;
      ST_DIV: begin
        if (sts.div_done) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply      = 1'b1;
        pass_left_next = pass_left - 1'b1;
        state_next     = (pass_left == 16'd1) ? ST_OUT : ST_PASS;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.clr_idx = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end
endmodule

FILE: design/linear_regression_gradient_descent.sv
// Top level of the batch gradient-descent line fitter.
// Uses lrgd_pkg, lrgd_ctrl, lrgd_datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | sample_x, sample_y, final_point
//  out     | output    | out_valid/ out_stall | fitted_slope, fitted_intercept, overflowed
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// Points transfer at one per cycle while loading. A final point starts the fit:
// each pass reads, multiplies and accumulates every stored point, then runs the
// two serial 64-bit divides and applies the deltas; the result is valid after
// pass_count passes (the next cycle when pass_count is 0).
// Input stalls from the final point until the result transfers.
// Reset is synchronous; the point store is not cleared.
module linear_regression_gradient_descent #(
  parameter int MAX_POINTS = lrgd_pkg::MAX_POINTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        sample_x,
  input  logic signed [31:0] sample_y,
  input  logic               final_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] fitted_slope,
  output logic signed [31:0] fitted_intercept,
  output logic               overflowed,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lrgd_pkg::*;

  logic [15:0] step_rate, pass_count;
  cmd_t        cmd;
  sts_t        sts;
  logic        busy, in_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate  <= STEP_RATE_RST;
      pass_count <= PASS_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_RATE:  step_rate  <= cfg_data;
        REG_PASS_COUNT: pass_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  lrgd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(final_point),
    .pass_count(pass_count), .sts(sts), .cmd(cmd), .busy(busy),
    .out_valid(out_valid), .out_stall(out_stall)
  );

  lrgd_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .load(in_fire),
    .in_x(sample_x), .in_y(sample_y), .step_rate(step_rate),
    .slope(fitted_slope), .intercept(fitted_intercept), .sat(overflowed)
  );
endmodule

FILE: design/lrgd_checker.sv
// Port-level checks for the line fitter, bound to the top level.
// Uses lrgd_pkg.
module lrgd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        final_point,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] fitted_slope,
  input logic        overflowed
);
  import lrgd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(fitted_slope))
    else $error("result dropped while stalled");

  a_last_locks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && final_point |=> in_stall)
    else $error("input open during fit");

  a_no_in_with_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while result waits");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    overflowed |=> overflowed)
    else $error("overflow flag cleared");
endmodule

bind linear_regression_gradient_descent lrgd_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .final_point(final_point), .out_valid(out_valid), .out_stall(out_stall),
  .fitted_slope(fitted_slope), .overflowed(overflowed)
);
